// ===== hw/rtl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// Shared sizes and types of the heapsort engine: store geometry, the store
// access request and the result handed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package hs_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = CNT_W + 1;

  typedef logic signed [31:0] elem_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    elem_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    elem_t value;
    logic  eos;
    logic  ovf;
  } emit_t;

endpackage

// ===== hw/rtl/heapsort_engine.sv =====
// Loading accepts transactions while the sequencer is idle; after the last-marked
// one the set is heapified and sorted in place, paced by the store's separate
// read and write ports and the one shared comparator; results then leave one
// by one from the store. The engine sorts one set at a time.
// Reset clears the sequencer, fill count, drop flag, output valid and the
// descending bit; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// heapsort_engine
// Collects a set of signed elements, heapsorts it in place and streams the
// sorted set out with an end-of-set mark and an overflow flag.
// ----------------------------------------------------------------------------
module heapsort_engine
  import hs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic signed [31:0] value,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic signed [31:0] sorted_value,
  output logic        end_of_set,
  output logic        overflow
);

  logic     descending;
  mem_req_t mem_req;
  elem_t    mem_rdata;
  emit_t    emit;
  logic     emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_wen) begin
      descending <= cfg_wdata;
    end
  end

  hs_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  hs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .value      (value),
    .last       (last),
    .descending (descending),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  // output register frees the sequencer from the consumer
  assign emit_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_ready) begin
      result_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      sorted_value <= emit.value;
      end_of_set   <= emit.eos;
      overflow     <= emit.ovf;
    end
  end

  a_no_emit_when_loading: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && emit.valid))
    else $error("sequencer offers a result while taking input");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.eos && emit_ready) |=> item_ready)
    else $error("sequencer not idle after the last result of a set");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit_ready) |=> (result_valid && sorted_value == $past(emit.value)))
    else $error("result register missed a sorted element");

endmodule

// ===== hw/rtl/hs_cmp.sv =====
// ----------------------------------------------------------------------------
// hs_cmp
// Shared ordering comparator: tells whether element a sits above element b.
// ----------------------------------------------------------------------------
module hs_cmp
  import hs_pkg::*;
(
  input  elem_t a,
  input  elem_t b,
  input  logic  descending,
  output logic  a_higher
);

  // max-heap for ascending output, min-heap for descending output
  assign a_higher = descending ? (a < b) : (a > b);

endmodule

// ===== hw/rtl/hs_store.sv =====
// ----------------------------------------------------------------------------
// hs_store
// Element store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module hs_store
  import hs_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output elem_t    rdata
);

  elem_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hw/rtl/hs_seq.sv =====
// ----------------------------------------------------------------------------
// hs_seq
// Heapsort sequencer: loads the set, builds the heap, extracts the root
// repeatedly with a hole-based sift-down and reads the sorted set out.
// ----------------------------------------------------------------------------
module hs_seq
  import hs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  elem_t    value,
  input  logic     last,
  input  logic     descending,
  output mem_req_t mem_req,
  input  elem_t    mem_rdata,
  output emit_t    emit,
  input  logic     emit_ready
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_BUILD   = 12'b0000_0000_0010,
    S_GETCUR  = 12'b0000_0000_0100,
    S_CHILD   = 12'b0000_0000_1000,
    S_RDL     = 12'b0000_0001_0000,
    S_CMP     = 12'b0000_0010_0000,
    S_SIFTEND = 12'b0000_0100_0000,
    S_EXT0    = 12'b0000_1000_0000,
    S_EXT1    = 12'b0001_0000_0000,
    S_EXT2    = 12'b0010_0000_0000,
    S_EMIT_RD = 12'b0100_0000_0000,
    S_EMIT    = 12'b1000_0000_0000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  fill;
  logic              dropped;
  logic              desc_q;
  logic              phase_ext;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] node;
  logic [CNT_W-1:0]  size;
  logic [ADDR_W-1:0] k;
  elem_t             cur;
  elem_t             best_val;
  logic              best_left;

  logic [IDX_W-1:0]  left;
  logic [IDX_W-1:0]  right;
  logic              has_left;
  logic              has_right;
  logic              full;
  logic [CNT_W-1:0]  n_load;
  logic              accept;
  logic              last_out;
  elem_t             cmp_b;
  logic              higher;

  assign left      = IDX_W'({node, 1'b1});
  assign right     = left + 1'b1;
  assign has_left  = left < IDX_W'(size);
  assign has_right = right < IDX_W'(size);
  assign full      = (fill == CNT_W'(MAX_ITEMS));
  assign n_load    = full ? fill : fill + 1'b1;
  assign item_ready = (state == S_IDLE);
  assign accept    = item_valid && item_ready;
  assign last_out  = ((CNT_W'(k) + 1'b1) == fill);

  // one comparator serves both child checks of a sift step
  assign cmp_b = (state == S_CMP) ? best_val : cur;

  hs_cmp u_cmp (
    .a          (mem_rdata),
    .b          (cmp_b),
    .descending (desc_q),
    .a_higher   (higher)
  );

  always_comb begin
    mem_req = '0;
    emit    = '0;
    unique case (state)
      S_IDLE: begin
        mem_req.we    = accept && !full;
        mem_req.waddr = fill[ADDR_W-1:0];
        mem_req.wdata = value;
      end
      S_BUILD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx;
      end
      S_GETCUR: begin
      end
      S_CHILD: begin
        mem_req.we    = !has_left;
        mem_req.waddr = node;
        mem_req.wdata = cur;
        mem_req.re    = has_left;
        mem_req.raddr = left[ADDR_W-1:0];
      end
      S_RDL: begin
        mem_req.re    = has_right;
        mem_req.raddr = right[ADDR_W-1:0];
      end
      S_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = node;
        if (has_right && higher) begin
          mem_req.wdata = mem_rdata;
        end else if (best_left) begin
          mem_req.wdata = best_val;
        end else begin
          mem_req.wdata = cur;
        end
      end
      S_SIFTEND: begin
      end
      S_EXT0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx;
      end
      S_EXT1: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
      end
      S_EXT2: begin
        // old root goes to the end of the shrinking heap
        mem_req.we    = 1'b1;
        mem_req.waddr = idx;
        mem_req.wdata = mem_rdata;
      end
      S_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = k;
      end
      S_EMIT: begin
        emit.valid = 1'b1;
        emit.value = mem_rdata;
        emit.eos   = last_out;
        emit.ovf   = dropped;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      dropped   <= 1'b0;
      phase_ext <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= n_load;
            if (full) begin
              dropped <= 1'b1;
            end
            if (last) begin
              desc_q    <= descending;
              phase_ext <= 1'b0;
              k         <= '0;
              idx       <= ADDR_W'((n_load - CNT_W'(2)) >> 1);
              if (n_load < CNT_W'(2)) begin
                state <= S_EMIT_RD;
              end else begin
                state <= S_BUILD;
              end
            end
          end
        end
        S_BUILD: begin
          node  <= idx;
          size  <= fill;
          state <= S_GETCUR;
        end
        S_GETCUR: begin
          cur   <= mem_rdata;
          state <= S_CHILD;
        end
        S_CHILD: begin
          state <= has_left ? S_RDL : S_SIFTEND;
        end
        S_RDL: begin
          best_left <= higher;
          best_val  <= higher ? mem_rdata : cur;
          state     <= S_CMP;
        end
        S_CMP: begin
          if (has_right && higher) begin
            node  <= right[ADDR_W-1:0];
            state <= S_CHILD;
          end else if (best_left) begin
            node  <= left[ADDR_W-1:0];
            state <= S_CHILD;
          end else begin
            state <= S_SIFTEND;
          end
        end
        S_SIFTEND: begin
          if (!phase_ext) begin
            if (idx == '0) begin
              phase_ext <= 1'b1;
              idx       <= ADDR_W'(fill - 1'b1);
              state     <= S_EXT0;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_BUILD;
            end
          end else if (idx == ADDR_W'(1)) begin
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_EXT0;
          end
        end
        S_EXT0: begin
          state <= S_EXT1;
        end
        S_EXT1: begin
          cur   <= mem_rdata;
          state <= S_EXT2;
        end
        S_EXT2: begin
          node  <= '0;
          size  <= CNT_W'(idx);
          state <= S_CHILD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ready) begin
            if (last_out) begin
              fill    <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_heapsort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heapsort_engine
// Streams sets of signed elements into the heapsort engine with random gaps on
// both sides, predicts each sorted set and checks every result transaction
// (value, end-of-set mark, overflow flag) in order against the prediction.
// ----------------------------------------------------------------------------

typedef struct {
  hs_pkg::elem_t value;
  bit            eos;
  bit            ovf;
} sorted_result_t;

class sorted_set_board;
  bit             descending;
  hs_pkg::elem_t  held_elems[$];
  bit             dropped;
  sorted_result_t expected_sorted[$];
  int             mismatch_count;

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task set_order(bit desc);
    descending = desc;
  endtask

  function int pending();
    return expected_sorted.size();
  endfunction

  function bit ranks_first(hs_pkg::elem_t a, hs_pkg::elem_t b);
    return descending ? (a > b) : (a < b);
  endfunction

  // insertion sort of the held set, then one expectation per element
  task sort_held();
    hs_pkg::elem_t  key;
    int             j;
    sorted_result_t res;
    for (int i = 1; i < held_elems.size(); i++) begin
      key = held_elems[i];
      j = i;
      while (j > 0 && ranks_first(key, held_elems[j-1])) begin
        held_elems[j] = held_elems[j-1];
        j--;
      end
      held_elems[j] = key;
    end
    for (int k = 0; k < held_elems.size(); k++) begin
      res.value = held_elems[k];
      res.eos   = (k == held_elems.size() - 1);
      res.ovf   = dropped;
      expected_sorted.push_back(res);
    end
    held_elems.delete();
    dropped = 1'b0;
  endtask

  task note_element(hs_pkg::elem_t v, bit is_last);
    if (held_elems.size() < hs_pkg::MAX_ITEMS) held_elems.push_back(v);
    else dropped = 1'b1;
    if (is_last) sort_held();
  endtask

  task check_result(hs_pkg::elem_t v, bit eos, bit ovf);
    sorted_result_t exp_res;
    if (expected_sorted.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d", v));
    end else begin
      exp_res = expected_sorted.pop_front();
      if (v !== exp_res.value)
        report_mismatch($sformatf("sorted_value %0d, expected %0d", v, exp_res.value));
      if (eos !== exp_res.eos)
        report_mismatch($sformatf("end_of_set %b, expected %b", eos, exp_res.eos));
      if (ovf !== exp_res.ovf)
        report_mismatch($sformatf("overflow %b, expected %b", ovf, exp_res.ovf));
    end
  endtask
endclass

module tb_heapsort_engine;
  import hs_pkg::*;

  localparam int RANDOM_ITEMS = 185;
  localparam int IDLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic        cfg_wdata;
  logic        item_valid;
  logic        item_ready;
  elem_t       value;
  logic        last;
  logic        result_valid;
  logic        result_ready;
  elem_t       sorted_value;
  logic        end_of_set;
  logic        overflow;

  sorted_set_board board;
  bit              tx_calm;
  bit              rx_calm;
  int              sent_random;
  int              set_num;
  int              set_size;

  heapsort_engine uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .value        (value),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .overflow     (overflow)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // full range most of the time, narrow range for duplicates, some extremes
  function automatic elem_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task send_element(elem_t v, bit is_last);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    last       <= is_last;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // register write only once the engine has drained
  task write_order(bit desc);
    item_valid <= 1'b0;
    // let the monitor note the last accepted transaction first
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_order(desc);
  endtask

  task send_random_set(int n);
    for (int i = 0; i < n; i++) send_element(pick_value(), i == n - 1);
    sent_random += n;
  endtask

  // sink: random stalls, with calm stretches toggled now and then
  initial begin
    int gap;
    result_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) board.note_element(value, last);
      if (result_valid && result_ready)
        board.check_result(sorted_value, end_of_set, overflow);
    end
  end

  initial begin
    board = new();
    rst        <= 1'b1;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= 1'b0;
    item_valid <= 1'b0;
    value      <= '0;
    last       <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single elements, extremes, duplicates, both orders
    write_order(1'b0);
    send_element(32'sh7fff_ffff, 1'b1);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh0, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sd1, 1'b1);
    write_order(1'b1);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sh0, 1'b0);
    send_element(32'sd1, 1'b0);
    send_element(32'sd5, 1'b0);
    send_element(32'sd5, 1'b1);
    send_element(32'sh8000_0000, 1'b1);
    send_element(-32'sd7, 1'b0);
    send_element(-32'sd7, 1'b0);
    send_element(-32'sd7, 1'b0);
    send_element(-32'sd7, 1'b1);
    write_order(1'b0);
    send_element(32'sd3, 1'b0);
    send_element(-32'sd3, 1'b1);

    // random sets: mostly small, a full store, overflow with the last dropped
    sent_random = 0;
    set_num = 0;
    while (sent_random < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_order($urandom_range(0, 1));
      case (set_num)
        1: set_size = MAX_ITEMS + 1;
        4: set_size = MAX_ITEMS;
        default: begin
          if ($urandom_range(0, 9) == 0) set_size = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
          else set_size = $urandom_range(1, 12);
        end
      endcase
      send_random_set(set_size);
      set_num++;
    end
    // extremes of the register once more at the end
    write_order(1'b1);
    send_random_set($urandom_range(2, 9));
    write_order(1'b0);
    send_random_set($urandom_range(2, 9));

    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
